@@ sv/eastr_pkg.sv @@
// ----------------------------------------------------------------------------
// eastr_pkg
// Shared types and constants for the encoder angle and speed tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package eastr_pkg;

    // Stream word layout.
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 128;

    // Field and register widths.
    localparam int TIME_W     = 32;
    localparam int OFF_W      = 32;
    localparam int WRAP_W     = 8;
    localparam int ANGLE_W    = 64;
    localparam int SPEED_W    = 64;
    localparam int DEG_W      = 24;
    localparam int WIN_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_STEP   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STEER_DEG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INT    = 3'd4;

    // Speed path: |angle difference| < 2^57, times one million < 2^78.
    localparam int         MAG_W       = 58;
    localparam int         NUM_W       = 78;
    localparam int         DIV_CNT_W   = 7;
    localparam logic [19:0] SPEED_SCALE = 20'd1000000;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_STEP   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        wheel;
        logic              step_up;
        logic [TIME_W-1:0] time_us;
    } t_op;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [SPEED_W-1:0] speed;
        logic               speed_updated;
    } t_result;

endpackage

`default_nettype wire

@@ sv/eastr_front.sv @@
// ----------------------------------------------------------------------------
// eastr_front
// Accepts input words and classifies them into operations for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module eastr_front (
    input  wire logic                              i_tvalid,
    output      logic                              o_tready,
    input  wire logic [eastr_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  wire logic [eastr_pkg::IN_TUSER_W-1:0]  i_tuser,
    input  wire logic                              i_full,
    output      logic                              o_push,
    output      eastr_pkg::t_op                    o_op
);

    logic [1:0] cmd;
    logic [1:0] wheel;

    assign cmd   = i_tuser[1:0];
    assign wheel = i_tuser[3:2];

    // A speed sample only means something on a driving wheel (wheel bit 1 set).
    always_comb begin
        o_op.wheel   = wheel;
        o_op.step_up = i_tdata[0];
        o_op.time_us = i_tdata[eastr_pkg::TIME_W:1];
        case (cmd)
            eastr_pkg::CMD_STEP:   o_op.kind = eastr_pkg::OP_STEP;
            eastr_pkg::CMD_SAMPLE: o_op.kind = wheel[1] ? eastr_pkg::OP_SAMPLE
                                                         : eastr_pkg::OP_NONE;
            eastr_pkg::CMD_CLEAR:  o_op.kind = eastr_pkg::OP_CLEAR;
            default:               o_op.kind = eastr_pkg::OP_NONE;
        endcase
    end

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

endmodule

`default_nettype wire

@@ sv/eastr_fifo.sv @@
// ----------------------------------------------------------------------------
// eastr_fifo
// Short operation queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module eastr_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire eastr_pkg::t_op i_op,
    input  wire logic           i_pop,
    output      eastr_pkg::t_op o_op,
    output      logic           o_empty,
    output      logic           o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    eastr_pkg::t_op r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/eastr_div.sv @@
// ----------------------------------------------------------------------------
// eastr_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eastr_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [eastr_pkg::NUM_W-1:0]       i_num,
    input  wire logic [eastr_pkg::TIME_W-1:0]      i_den,
    output      logic                              o_done,
    output      logic [eastr_pkg::NUM_W-1:0]       o_quo
);

    localparam int NW = eastr_pkg::NUM_W;
    localparam int DW = eastr_pkg::TIME_W;

    logic                              r_busy;
    logic                              r_done;
    logic [eastr_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [DW-1:0]                     r_rem;
    logic [DW-1:0]                     r_den;
    logic [NW-1:0]                     r_q;
    logic [DW:0]                       rem_sh;
    logic [DW:0]                       den_x;
    logic [DW:0]                       rem_sub;
    logic                              ge;
    logic [DW-1:0]                     n_rem;

    // The remainder stays below the divisor, so the shifted value fits DW+1 bits.
    assign rem_sh  = {r_rem, r_q[NW-1]};
    assign den_x   = {1'b0, r_den};
    assign ge      = (rem_sh >= den_x);
    assign rem_sub = rem_sh - den_x;
    assign n_rem   = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

    assign o_done = r_done;
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= eastr_pkg::DIV_CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == eastr_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/eastr_exec.sv @@
// ----------------------------------------------------------------------------
// eastr_exec
// Execution unit: channel state, angle arithmetic, speed and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module eastr_exec (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire eastr_pkg::t_cfg_wr  i_cfg,
    input  wire logic                i_empty,
    input  wire eastr_pkg::t_op      i_op,
    output      logic                o_pop,
    output      logic                o_tvalid,
    input  wire logic                i_tready,
    output      eastr_pkg::t_result  o_result
);

    localparam int OW = eastr_pkg::OFF_W;
    localparam int AW = eastr_pkg::ANGLE_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_UPD  = 11'b000_0000_0010,
        S_MUL  = 11'b000_0000_0100,
        S_SUM  = 11'b000_0000_1000,
        S_DIFF = 11'b000_0001_0000,
        S_PLO  = 11'b000_0010_0000,
        S_PHI  = 11'b000_0100_0000,
        S_NUM  = 11'b000_1000_0000,
        S_DIV  = 11'b001_0000_0000,
        S_WR   = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration.
    logic [eastr_pkg::DEG_W-1:0]  r_steer_deg;
    logic [eastr_pkg::DEG_W-1:0]  r_drive_deg;
    logic [eastr_pkg::WIN_W-1:0]  r_wrap_win;
    logic [31:0]                  r_wrap_angle;
    logic [eastr_pkg::TIME_W-1:0] r_min_int;

    // Channel state.
    logic [OW-1:0]                    r_offset     [4];
    logic [eastr_pkg::WRAP_W-1:0]     r_wrap       [2];
    logic [AW-1:0]                    r_prev_angle [2];
    logic [eastr_pkg::TIME_W-1:0]     r_prev_time  [2];
    logic [eastr_pkg::SPEED_W-1:0]    r_last_speed [2];

    // Work registers.
    eastr_pkg::t_op               r_op;
    logic                         r_upd;
    logic                         r_take;
    logic signed [56:0]           r_p0;
    logic signed [40:0]           r_p1;
    logic [AW-1:0]                r_angle;
    logic                         r_neg;
    logic [eastr_pkg::MAG_W-1:0]  r_mag;
    logic [51:0]                  r_plo;
    logic [45:0]                  r_phi;
    logic                         r_out_valid;
    eastr_pkg::t_result           r_out;

    logic [1:0]                   w;
    logic                         d;
    logic                         is_drive;
    logic [OW-1:0]                off_cur;
    logic [OW-1:0]                off_step;
    logic signed [OW:0]           step_s;
    logic signed [OW:0]           win_s;
    logic                         win_on;
    logic                         wrap_hi;
    logic                         wrap_lo;
    logic signed [31:0]           mul_off;
    logic signed [24:0]           mul_deg;
    logic signed [56:0]           prod0;
    logic signed [7:0]            mul_wrap;
    logic signed [32:0]           mul_wang;
    logic signed [40:0]           prod1;
    logic [eastr_pkg::TIME_W-1:0] dt;
    logic [AW-1:0]                diff;
    logic                         div_start;
    logic [eastr_pkg::NUM_W-1:0]  div_num;
    logic                         div_done;
    logic [eastr_pkg::NUM_W-1:0]  div_quo;
    logic                         sat_pos;
    logic                         sat_neg;
    logic [eastr_pkg::SPEED_W-1:0] mag_q;
    logic [eastr_pkg::SPEED_W-1:0] speed_new;
    logic                         out_load;

    assign w        = r_op.wheel;
    assign d        = r_op.wheel[0];
    assign is_drive = r_op.wheel[1];

    // Step and steering wrap check.
    assign off_cur  = r_offset[w];
    assign off_step = r_op.step_up ? off_cur + 1'b1 : off_cur - 1'b1;
    assign step_s   = $signed({off_step[OW-1], off_step});
    assign win_s    = $signed({{(OW + 1 - eastr_pkg::WIN_W){1'b0}}, r_wrap_win});
    assign win_on   = !is_drive && (r_wrap_win != '0);
    assign wrap_hi  = win_on && (step_s >= win_s);
    assign wrap_lo  = win_on && (step_s <= -win_s);

    // Angle products; the wrap term only exists on steering wheels.
    assign mul_off  = $signed(r_offset[w]);
    assign mul_deg  = $signed({1'b0, is_drive ? r_drive_deg : r_steer_deg});
    assign prod0    = mul_off * mul_deg;
    assign mul_wrap = $signed(r_wrap[d]);
    assign mul_wang = $signed({1'b0, r_wrap_angle});
    assign prod1    = mul_wrap * mul_wang;

    assign dt   = r_op.time_us - r_prev_time[d];
    assign diff = r_angle - r_prev_angle[d];

    assign div_start = (r_state == S_NUM);
    assign div_num   = eastr_pkg::NUM_W'(r_plo) + {r_phi, 32'b0};

    eastr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (dt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Saturation: +(2^63 - 1) for a positive change, -2^63 for a negative one.
    assign sat_pos   = |div_quo[eastr_pkg::NUM_W-1:63];
    assign sat_neg   = (|div_quo[eastr_pkg::NUM_W-1:64]) || (div_quo[63] && |div_quo[62:0]);
    assign mag_q     = div_quo[63:0];
    assign speed_new = r_neg ? (sat_neg ? {1'b1, 63'b0} : -mag_q)
                             : (sat_pos ? {1'b0, {63{1'b1}}} : mag_q);

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_tready);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_tvalid = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_empty) n_state = S_UPD;
            S_UPD:  n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = (r_op.kind == eastr_pkg::OP_SAMPLE && r_take) ? S_DIFF : S_OUT;
            S_DIFF: n_state = S_PLO;
            S_PLO:  n_state = S_PHI;
            S_PHI:  n_state = S_NUM;
            S_NUM:  n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_WR;
            S_WR:   n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
        end
        if (r_state == S_MUL) begin
            r_p0   <= prod0;
            r_p1   <= is_drive ? '0 : prod1;
            r_take <= (dt != '0) && (dt >= r_min_int);
        end
        if (r_state == S_SUM) begin
            r_angle <= AW'(r_p0) + AW'(r_p1);
        end
        if (r_state == S_DIFF) begin
            r_neg <= diff[AW-1];
            r_mag <= eastr_pkg::MAG_W'(diff[AW-1] ? -diff : diff);
        end
        if (r_state == S_PLO) begin
            r_plo <= 52'(r_mag[31:0]) * 52'(eastr_pkg::SPEED_SCALE);
        end
        if (r_state == S_PHI) begin
            r_phi <= 46'(r_mag[eastr_pkg::MAG_W-1:32]) * 46'(eastr_pkg::SPEED_SCALE);
        end
        if (out_load) begin
            r_out.angle         <= r_angle;
            r_out.speed         <= is_drive ? r_last_speed[d] : '0;
            r_out.speed_updated <= r_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_upd        <= 1'b0;
            r_steer_deg  <= '0;
            r_drive_deg  <= '0;
            r_wrap_win   <= '0;
            r_wrap_angle <= '0;
            r_min_int    <= '0;
            for (int i = 0; i < 4; i++) begin
                r_offset[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_wrap[i]       <= '0;
                r_prev_angle[i] <= '0;
                r_prev_time[i]  <= '0;
                r_last_speed[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg.we) begin
                case (i_cfg.idx)
                    eastr_pkg::REG_STEER_DEG:  r_steer_deg  <= i_cfg.data[eastr_pkg::DEG_W-1:0];
                    eastr_pkg::REG_DRIVE_DEG:  r_drive_deg  <= i_cfg.data[eastr_pkg::DEG_W-1:0];
                    eastr_pkg::REG_WRAP_WIN:   r_wrap_win   <= i_cfg.data[eastr_pkg::WIN_W-1:0];
                    eastr_pkg::REG_WRAP_ANGLE: r_wrap_angle <= i_cfg.data;
                    eastr_pkg::REG_MIN_INT:    r_min_int    <= i_cfg.data;
                    default: ;
                endcase
            end

            if (o_pop) begin
                r_upd <= 1'b0;
            end

            if (r_state == S_UPD) begin
                case (r_op.kind)
                    eastr_pkg::OP_STEP: begin
                        if (wrap_hi) begin
                            r_offset[w] <= '0;
                            r_wrap[d]   <= r_wrap[d] + 1'b1;
                        end else if (wrap_lo) begin
                            r_offset[w] <= '0;
                            r_wrap[d]   <= r_wrap[d] - 1'b1;
                        end else begin
                            r_offset[w] <= off_step;
                        end
                    end
                    eastr_pkg::OP_CLEAR: r_offset[w] <= '0;
                    default: ;
                endcase
            end

            if (r_state == S_WR) begin
                r_last_speed[d] <= speed_new;
                r_prev_angle[d] <= r_angle;
                r_prev_time[d]  <= r_op.time_us;
                r_upd           <= 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/encoder_angle_speed_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_angle_speed_tracker_unit
// A count step, count reset or ignored command runs the execution states IDLE,
//   UPD, MUL, SUM and OUT, where its result is loaded into the output register;
//   the unit pops the next word from the queue only once it is back in IDLE.
// A speed sample that passes the interval check also runs DIFF, PLO, PHI, NUM,
//   DIV (the 78-step bit-serial divider for 1e6 * dangle / dt) and WR.
// Reset (i_rst_n low, synchronous) clears all channel state, the configuration
//   registers, the queue and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

// Tracks four encoder channels. Wheels 0 and 1 are steering channels, wheels
// 2 and 3 are driving channels. Every accepted word yields exactly one result
// word with the named wheel's angle, its last speed and an update flag.
//
// Structure:
//   eastr_front  decodes the input word into an operation. A speed sample on a
//                steering wheel and the unused command code become no-ops.
//   eastr_fifo   a short queue of operations, so the input side keeps
//                accepting, until the queue is full, while the execution unit
//                is working or its result waits for the downstream side.
//   eastr_exec   holds the channel state and configuration, applies the count
//                update, forms the angle with one multiply step, runs the speed
//                division and loads the output register.
//
// The output register decouples the result from the execution unit: the unit
// only stalls when a second result is ready before the first one was taken.
module encoder_angle_speed_tracker_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream.
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // tdata, low bit up: step_up [0], time_us [32:1], zero fill [39:33].
    input  wire logic [eastr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser, low bit up: cmd [1:0], wheel [3:2].
    input  wire logic [eastr_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // Result stream.
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata, low bit up: angle [63:0], speed [127:64].
    output      logic [eastr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: speed_updated [0].
    output      logic [0:0]                          m_axis_tuser,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [eastr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [eastr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    eastr_pkg::t_op      front_op;
    eastr_pkg::t_op      queue_op;
    eastr_pkg::t_cfg_wr  cfg_wr;
    eastr_pkg::t_result  result;
    logic                push;
    logic                pop;
    logic                q_empty;
    logic                q_full;

    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    eastr_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_full   (q_full),
        .o_push   (push),
        .o_op     (front_op)
    );

    eastr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (queue_op),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    eastr_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_empty  (q_empty),
        .i_op     (queue_op),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_result (result)
    );

    // Angle in the low half, speed in the high half of the result word.
    assign m_axis_tdata = {result.speed, result.angle};
    assign m_axis_tuser = result.speed_updated;

endmodule

`default_nettype wire

@@ sv/eastr_chk.sv @@
// ----------------------------------------------------------------------------
// eastr_chk
// Port-level checks for the encoder angle and speed tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module eastr_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [eastr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire logic [0:0]                          m_axis_tuser,
    input wire logic                                i_cfg_we
);

    logic       s_acc;
    logic       m_acc;
    logic [7:0] r_outst;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // Words accepted whose result word has not been taken yet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else if (s_acc && !m_acc) begin
            r_outst <= r_outst + 1'b1;
        end else if (m_acc && !s_acc) begin
            r_outst <= r_outst - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_outst != 8'd0)
        else $error("result word without an accepted input word");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && r_outst == 8'd0 |=> !m_axis_tvalid)
        else $error("result word appeared one cycle after acceptance");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Configuration is only written while no word is in flight.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> r_outst == 8'd0)
        else $error("configuration written while a word was in flight");

endmodule

bind encoder_angle_speed_tracker_unit eastr_chk u_eastr_chk (.*);

`default_nettype wire

@@ sim/tb_encoder_angle_speed_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_angle_speed_tracker_unit
// Self-checking bench for the four-channel encoder angle and speed tracker.
// A cycle-free model of the channel state predicts the angle, speed and
// update flag of every accepted word, and each result word is checked in
// order. A short directed part is followed by random phases that change the
// configuration and the amount of idling on both stream sides.
// ----------------------------------------------------------------------------

// Predicts the result of each accepted word and checks results in arrival order.
class angle_speed_board;
    // Register copies, already cut to their widths.
    bit [eastr_pkg::DEG_W-1:0] steer_scale;
    bit [eastr_pkg::DEG_W-1:0] drive_scale;
    bit [eastr_pkg::WIN_W-1:0] wrap_window;
    bit [31:0]                 wrap_angle;
    bit [31:0]                 min_gap;

    // Channel state. All of it starts at zero, as after reset.
    bit [eastr_pkg::OFF_W-1:0]  offset [4];
    bit [eastr_pkg::WRAP_W-1:0] wraps [4];
    longint                     base_angle [2];
    bit [eastr_pkg::TIME_W-1:0] base_time [2];
    longint                     held_speed [2];

    eastr_pkg::t_result due_reports [$];
    int unsigned        mismatches;

    function void set_reg(logic [eastr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            eastr_pkg::REG_STEER_DEG:  steer_scale = data[eastr_pkg::DEG_W-1:0];
            eastr_pkg::REG_DRIVE_DEG:  drive_scale = data[eastr_pkg::DEG_W-1:0];
            eastr_pkg::REG_WRAP_WIN:   wrap_window = data[eastr_pkg::WIN_W-1:0];
            eastr_pkg::REG_WRAP_ANGLE: wrap_angle = data;
            eastr_pkg::REG_MIN_INT:    min_gap = data;
            default: ;
        endcase
    endfunction

    // Offset times scale; steering wheels add their wrap count times the wrap angle.
    function longint angle_of(logic [1:0] wheel);
        longint off;
        off = longint'($signed(offset[wheel]));
        if (wheel < 2)
            return off * longint'(steer_scale) +
                   longint'($signed(wraps[wheel])) * longint'(wrap_angle);
        return off * longint'(drive_scale);
    endfunction

    // One million times delta over dt, truncated toward zero and saturated.
    function longint rate_of(longint delta, bit [31:0] dt);
        bit [127:0] num;
        bit [127:0] quo;
        bit         neg;
        neg = delta < 0;
        num = neg ? 128'(-delta) : 128'(delta);
        quo = (num * 128'd1000000) / {96'd0, dt};
        if (!neg)
            return (quo > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                    : longint'(quo[63:0]);
        return (quo >= 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                 : -longint'(quo[63:0]);
    endfunction

    function void note_word(logic [1:0] cmd, logic [1:0] wheel, logic up,
                            logic [31:0] stamp);
        eastr_pkg::t_result rep;
        longint             off;
        longint             cur;
        bit [31:0]          dt;
        bit                 d;
        bit                 updated;
        updated = 1'b0;
        // Driving wheels 2 and 3 own the speed slots 0 and 1.
        d = wheel[0];
        case (cmd)
            eastr_pkg::CMD_STEP: begin
                offset[wheel] = up ? offset[wheel] + 1 : offset[wheel] - 1;
                if (wheel < 2 && wrap_window != 0) begin
                    off = longint'($signed(offset[wheel]));
                    if (off >= longint'(wrap_window)) begin
                        offset[wheel] = '0;
                        wraps[wheel]  = wraps[wheel] + 1;
                    end else if (off <= -longint'(wrap_window)) begin
                        offset[wheel] = '0;
                        wraps[wheel]  = wraps[wheel] - 1;
                    end
                end
            end
            eastr_pkg::CMD_CLEAR: begin
                offset[wheel] = '0;
            end
            eastr_pkg::CMD_SAMPLE: begin
                if (wheel >= 2) begin
                    dt = stamp - base_time[d];
                    if (dt != 0 && dt >= min_gap) begin
                        cur           = angle_of(wheel);
                        held_speed[d] = rate_of(cur - base_angle[d], dt);
                        base_angle[d] = cur;
                        base_time[d]  = stamp;
                        updated       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        rep.angle         = angle_of(wheel);
        rep.speed         = (wheel >= 2) ? held_speed[d] : 64'd0;
        rep.speed_updated = updated;
        due_reports.push_back(rep);
    endfunction

    function void report(string field, longint want, longint got);
        mismatches++;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_report(logic [63:0] angle, logic [63:0] speed, logic updated);
        eastr_pkg::t_result want;
        if (due_reports.size() == 0) begin
            mismatches++;
            $error("result word arrived with no expectation waiting");
            return;
        end
        want = due_reports.pop_front();
        if (want.angle !== angle)
            report("angle", want.angle, angle);
        if (want.speed !== speed)
            report("speed", want.speed, speed);
        if (want.speed_updated !== updated)
            report("speed_updated", longint'(want.speed_updated), longint'(updated));
    endfunction

    function int outstanding();
        return due_reports.size();
    endfunction
endclass

module tb_encoder_angle_speed_tracker_unit;
    import eastr_pkg::*;

    // The unused command code; the block must report the wheel and change nothing.
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    // Longest correct quiet stretch is the receiver hold-off plus a speed
    // division and a run of random stalls; QUIET_LIMIT is several times that.
    localparam int QUIET_LIMIT    = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    // END_PAUSE outlasts the slowest word, a speed sample, so strays show up.
    localparam int END_PAUSE      = 200;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata, low bit up: step_up, time_us, zero fill.
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // tuser, low bit up: cmd, wheel.
    logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata, low bit up: angle, speed.
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // tuser: speed_updated.
    logic [0:0]              m_axis_tuser;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    angle_speed_board board;

    // Idling knobs of the current phase, in percent of cycles.
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    // The main process asks for a long receiver hold-off; the receiver counts it.
    bit          holdoff_req = 1'b0;
    int unsigned holdoff_left = 0;
    int unsigned quiet_cycles = 0;

    // Minimum sample interval currently programmed, used to aim sample times.
    logic [31:0] cur_min_gap = '0;
    // Running timestamp per driving wheel for well-formed sample sequences.
    logic [31:0] stream_clock [2] = '{32'd0, 32'd0};

    encoder_angle_speed_tracker_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Both handshakes are sampled at the rising edge, before the block's own
    // updates of that edge land. The result check runs first, so a word can
    // never be matched against the expectation of a word taken in the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_report(m_axis_tdata[63:0], m_axis_tdata[127:64],
                                   m_axis_tuser[0]);
            if (s_axis_tvalid && s_axis_tready)
                board.note_word(s_axis_tuser[1:0], s_axis_tuser[3:2],
                                s_axis_tdata[0], s_axis_tdata[32:1]);
        end
    end

    // Receiver: random stalls per phase, or a long hold-off on request so that
    // the block fills up and pushes back on its input.
    always @(negedge i_clk) begin
        if (holdoff_req) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_req  = 1'b0;
        end
        if (holdoff_left != 0) begin
            holdoff_left  = holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one word, with random idle cycles first, and returns at the falling
    // edge after it was taken. Valid stays high into the next call unless that
    // call idles, so it is never lowered and raised in one step.
    task automatic send_word(input logic [1:0] cmd, input logic [1:0] wheel,
                             input logic up, input logic [31:0] stamp);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, stamp, up};
        s_axis_tuser  <= {wheel, cmd};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every expected result word has arrived.
    // Each word yields exactly one result, so the block is idle afterwards.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        board.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Writes all five registers back to back; wide values exercise the masking
    // of the narrower registers.
    task automatic apply_settings(input logic [31:0] steer, input logic [31:0] drive,
                                  input logic [31:0] window, input logic [31:0] wrap_deg,
                                  input logic [31:0] min_us);
        write_reg(REG_STEER_DEG, steer);
        write_reg(REG_DRIVE_DEG, drive);
        write_reg(REG_WRAP_WIN, window);
        write_reg(REG_WRAP_ANGLE, wrap_deg);
        write_reg(REG_MIN_INT, min_us);
        i_cfg_we    <= 1'b0;
        cur_min_gap = min_us;
    endtask

    // Random words. Most samples go to a driving wheel with a time step aimed at
    // the programmed interval; some fall short, repeat the time or are wild.
    // In a wrap walk nearly every word steps a steering wheel, mostly upward,
    // so the 8-bit wrap counter rolls over.
    task automatic run_phase(input int unsigned words, input int unsigned src_pct,
                             input int unsigned sink_pct, input int unsigned up_pct,
                             input bit wrap_walk, input int holdoff_at);
        logic [1:0]  cmd;
        logic [1:0]  wheel;
        logic        up;
        logic [31:0] stamp;
        logic [31:0] gap;
        int unsigned pick;
        int unsigned sel;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < words; i++) begin
            if (i == holdoff_at)
                holdoff_req = 1'b1;
            pick  = $urandom_range(0, 99);
            cmd   = CMD_STEP;
            wheel = 2'($urandom_range(0, 3));
            up    = ($urandom_range(0, 99) < up_pct);
            stamp = $urandom;
            if (wrap_walk && pick < 85) begin
                wheel = (pick < 75) ? 2'd0 : 2'd1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    cmd = CMD_STEP;
                end else if (pick < 72) begin
                    cmd = CMD_SAMPLE;
                    if ($urandom_range(0, 99) < 85)
                        wheel = {1'b1, 1'($urandom_range(0, 1))};
                    sel = $urandom_range(0, 99);
                    if (sel < 65)
                        gap = cur_min_gap + $urandom_range(1, 3000);
                    else if (sel < 80)
                        gap = (cur_min_gap > 1) ? $urandom_range(1, cur_min_gap - 1) : 32'd0;
                    else if (sel < 88)
                        gap = 32'd0;
                    else if (sel < 94)
                        gap = cur_min_gap;
                    else
                        gap = $urandom;
                    stamp = stream_clock[wheel[0]] + gap;
                    stream_clock[wheel[0]] = stamp;
                end else if (pick < 84) begin
                    cmd = CMD_CLEAR;
                end else if (pick < 90) begin
                    cmd = CMD_IGNORED;
                end else begin
                    cmd = 2'($urandom_range(0, 3));
                end
            end
            send_word(cmd, wheel, up, stamp);
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, first setting: unit steering scale, 2.5 degrees per
        // drive count, a window of three counts, 90 degrees per wrap and no
        // minimum interval.
        apply_settings(32'h0001_0000, 32'h0002_8000, 32'd3, 32'h005A_0000, 32'd0);
        // Steering up to the window wraps forward, then down past it wraps back.
        send_word(CMD_STEP, 2'd0, 1'b1, 32'd0);
        send_word(CMD_STEP, 2'd0, 1'b1, 32'd0);
        send_word(CMD_STEP, 2'd0, 1'b1, 32'd0);
        send_word(CMD_STEP, 2'd0, 1'b0, 32'd0);
        send_word(CMD_STEP, 2'd0, 1'b0, 32'd0);
        send_word(CMD_STEP, 2'd0, 1'b0, 32'd0);
        // A clear keeps the wrap count and drops only the offset.
        send_word(CMD_STEP, 2'd1, 1'b0, 32'd0);
        send_word(CMD_CLEAR, 2'd1, 1'b0, 32'd0);
        // Speed on the front drive wheel, then a sample with no elapsed time.
        send_word(CMD_STEP, 2'd2, 1'b1, 32'd0);
        send_word(CMD_STEP, 2'd2, 1'b1, 32'd0);
        send_word(CMD_SAMPLE, 2'd2, 1'b0, 32'd1000);
        send_word(CMD_SAMPLE, 2'd2, 1'b0, 32'd1000);
        // A sample on a steering wheel does nothing.
        send_word(CMD_SAMPLE, 2'd0, 1'b0, 32'd500);
        // Negative speed, then a timestamp that wraps around zero.
        send_word(CMD_STEP, 2'd3, 1'b0, 32'd0);
        send_word(CMD_SAMPLE, 2'd3, 1'b1, 32'hFFFF_FFF0);
        send_word(CMD_SAMPLE, 2'd3, 1'b1, 32'h0000_0010);
        // The unused command, with every data bit set.
        send_word(CMD_IGNORED, 2'd2, 1'b1, 32'hFFFF_FFFF);
        send_word(CMD_IGNORED, 2'd1, 1'b0, 32'd0);
        // Clearing a drive wheel makes the next speed negative.
        send_word(CMD_CLEAR, 2'd2, 1'b0, 32'd0);
        send_word(CMD_SAMPLE, 2'd2, 1'b0, 32'd2000);

        // Second setting: every scale at its top and a 100 us minimum interval.
        settle_block();
        apply_settings(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0000_7FFF, 32'hFFFF_FFFF, 32'd100);
        send_word(CMD_STEP, 2'd2, 1'b1, 32'd0);
        // Too soon, then exactly the minimum interval.
        send_word(CMD_SAMPLE, 2'd2, 1'b0, 32'd2050);
        send_word(CMD_SAMPLE, 2'd2, 1'b0, 32'd2100);
        send_word(CMD_STEP, 2'd0, 1'b1, 32'd0);
        send_word(CMD_SAMPLE, 2'd3, 1'b0, 32'd0);

        // Random phases, each with its own setting and idling.
        settle_block();
        apply_settings($urandom, $urandom, 32'($urandom_range(1, 6)), $urandom,
                       32'($urandom_range(0, 400)));
        run_phase(250, 0, 0, 50, 1'b0, -1);

        settle_block();
        apply_settings($urandom, $urandom, 32'($urandom_range(1, 20)), $urandom,
                       32'($urandom_range(0, 2000)));
        run_phase(250, 65, 0, 50, 1'b0, -1);

        // The receiver holds off once while words keep coming in.
        settle_block();
        apply_settings($urandom, $urandom, 32'd2, $urandom, 32'($urandom_range(0, 100)));
        run_phase(300, 0, 65, 60, 1'b0, 40);

        // Wrapping disabled: steering offsets run freely in both directions.
        settle_block();
        apply_settings($urandom, $urandom, 32'd0, $urandom, 32'd0);
        run_phase(250, 9, 9, 40, 1'b0, -1);

        // Largest scales and a one-count window, so the wrap counter rolls over.
        settle_block();
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0);
        run_phase(450, 0, 65, 95, 1'b1, -1);

        // Smallest scales, the widest window and the longest minimum interval.
        settle_block();
        apply_settings(32'd0, 32'd1, 32'h0000_7FFF, 32'd0, 32'hFFFF_FFFF);
        run_phase(150, 9, 9, 50, 1'b0, -1);

        settle_block();
        repeat (END_PAUSE) @(negedge i_clk);
        if (board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
